>>> hdl/lph_pkg.sv
// lph_pkg: shared types, constants and the load limit table for the linear probe hash map
// depends on nothing; imported by every module under hdl
package lph_pkg;

	localparam int CAPACITY = 256; // power of two, home slot is the low key bits
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KEY_W = 64;
	localparam int VAL_W = 64;
	localparam int PCT_W = 7;
	localparam int PCT_RANGE = 1 << PCT_W;
	localparam int PCT_MAX = 99;
	localparam int PCT_SCALE = 100;
	localparam int LOAD_LIMIT_RESET = 80;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [PCT_W-1:0] pct_t;

	typedef enum logic [1:0] {
		ST_FOUND   = 2'd0,
		ST_MISSING = 2'd1,
		ST_STORED  = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_SET = 1'b1
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] data_value;
		logic             value_is_empty;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

	typedef struct packed {
		logic  wr_en;
		idx_t  addr;
		slot_t wdata;
	} mem_cmd_t;

	typedef cnt_t limit_table_t [PCT_RANGE];

	// entry limit per percent setting, settings above the maximum clamp to it
	function automatic limit_table_t build_limit_table();
		limit_table_t t;
		int p;
		for (int i = 0; i < PCT_RANGE; i++) begin
			p = (i > PCT_MAX) ? PCT_MAX : i;
			t[i] = CNT_W'((CAPACITY * p) / PCT_SCALE);
		end
		return t;
	endfunction

	localparam limit_table_t LIMIT_TABLE = build_limit_table();

endpackage

>>> hdl/lph_slot_ram.sv
// lph_slot_ram: key and value storage, one address per cycle, registered read
// depends on lph_pkg
module lph_slot_ram (
	input  logic              clk,
	input  lph_pkg::mem_cmd_t cmd,
	output lph_pkg::slot_t    rd_data
);
	import lph_pkg::*;

	slot_t mem_q [CAPACITY];
	slot_t rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[cmd.addr] <= cmd.wdata;
		end else begin
			rd_q <= mem_q[cmd.addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> hdl/lph_probe_ctrl.sv
// lph_probe_ctrl: probe sequencer, shared key compare, occupancy bits and entry count
// depends on lph_pkg; drives lph_slot_ram through a mem_cmd_t
module lph_probe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lph_pkg::req_t     req,
	input  lph_pkg::cnt_t     limit,
	input  lph_pkg::slot_t    mem_rd,
	output lph_pkg::mem_cmd_t mem_cmd,
	output logic              busy,
	output logic              done,
	output lph_pkg::rsp_t     rsp
);
	import lph_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_PROBE = 3'b010,
		S_CMP   = 3'b100
	} state_t;

	state_t         state_q;
	req_t           req_q;
	idx_t           idx_q;
	idx_t           cnt_q;
	cnt_t           count_q;
	logic [CAPACITY-1:0] occ_q;
	logic           done_q;
	rsp_t           rsp_q;

	logic  slot_occ;
	logic  key_match;
	logic  last_probe;
	logic  resolve;
	logic  hit_empty;
	logic  hit_match;
	logic  store;
	logic  count_inc;
	rsp_t  rsp_n;

	assign slot_occ   = occ_q[idx_q];
	assign key_match  = (mem_rd.key == req_q.key);
	assign last_probe = (cnt_q == IDX_W'(CAPACITY - 1));

	always_comb begin
		resolve   = 1'b0;
		hit_empty = 1'b0;
		hit_match = 1'b0;
		unique case (state_q)
			S_PROBE: begin
				if (!slot_occ) begin
					resolve   = 1'b1;
					hit_empty = 1'b1;
				end
			end
			S_CMP: begin
				if (key_match) begin
					resolve   = 1'b1;
					hit_match = 1'b1;
				end else if (last_probe) begin
					resolve = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		store     = 1'b0;
		count_inc = 1'b0;
		rsp_n.status     = ST_MISSING;
		rsp_n.read_value = '0;
		if (req_q.op == OP_GET) begin
			if (hit_match) begin
				rsp_n.status     = ST_FOUND;
				rsp_n.read_value = mem_rd.value;
			end
		end else begin
			rsp_n.read_value = req_q.data_value;
			rsp_n.status     = ST_FULL;
			if (hit_match) begin
				rsp_n.status = ST_STORED;
				store        = resolve;
			end else if (hit_empty && (count_q < limit)) begin
				rsp_n.status = ST_STORED;
				store        = resolve;
				count_inc    = resolve;
			end
		end
	end

	always_comb begin
		mem_cmd.wr_en       = store;
		mem_cmd.addr        = idx_q;
		mem_cmd.wdata.key   = req_q.key;
		mem_cmd.wdata.value = req_q.value_is_empty ? '0 : req_q.data_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= resolve;
			if (store) begin
				occ_q[idx_q] <= !req_q.value_is_empty;
			end
			if (count_inc) begin
				count_q <= count_q + CNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					state_q <= resolve ? S_IDLE : S_CMP;
				end
				S_CMP: begin
					state_q <= resolve ? S_IDLE : S_PROBE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
			idx_q <= req.key[IDX_W-1:0];
			cnt_q <= '0;
		end else if (state_q == S_CMP && !resolve) begin
			idx_q <= idx_q + IDX_W'(1);
			cnt_q <= cnt_q + IDX_W'(1);
		end
		if (resolve) begin
			rsp_q <= rsp_n;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

>>> hdl/linear_probe_hash_map.sv
// linear_probe_hash_map: fixed-capacity key/value map, open addressing with linear probing
// depends on lph_pkg, lph_slot_ram, lph_probe_ctrl
//
// command channel: a word on req is taken at a clock edge with start high and busy low;
//   op get looks up req.key, op set writes req.key and req.data_value
// result channel: rsp holds the result word for exactly one cycle while done is high;
//   the receiver always takes it, there is no back-pressure
// config channel: cfg_data is the load limit percent, written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high, write only while busy is low
// timing: a probe that lands on an empty slot resolves in the probe state; a probe
//   of an occupied slot is a slot ram read in the probe state, then a key compare in
//   the shared comparator in the compare state; done is registered from the probe
//   that resolves, busy drops with done, so the next word is taken at the edge that
//   ends the done cycle
// reset: all slots empty, entry count zero, load limit 80 percent; the slot ram itself
//   is not cleared, empty slots are tracked in flip-flops, so commands are taken at once
module linear_probe_hash_map (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  lph_pkg::req_t        req,
	output logic                 done,
	output lph_pkg::rsp_t        rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  lph_pkg::pct_t        cfg_data
);
	import lph_pkg::*;

	cnt_t     limit_q;
	mem_cmd_t mem_cmd;
	slot_t    mem_rd;

	assign cfg_ready = 1'b1;

	// entry limit looked up once per config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_TABLE[LOAD_LIMIT_RESET];
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= LIMIT_TABLE[cfg_data];
		end
	end

	lph_slot_ram u_ram (
		.clk     (clk),
		.cmd     (mem_cmd),
		.rd_data (mem_rd)
	);

	lph_probe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.limit   (limit_q),
		.mem_rd  (mem_rd),
		.mem_cmd (mem_cmd),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp)
	);

endmodule

>>> tb/sv/testbench.sv
// testbench for linear_probe_hash_map: directed and random get/set words with load limit changes
// results are checked against a scoreboard that mirrors the slot table; needs lph_pkg and the rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lph_pkg::*;

	class hash_map_scoreboard;
		logic [KEY_W-1:0] slot_key [CAPACITY];
		logic [VAL_W-1:0] slot_val [CAPACITY];
		bit               slot_live [CAPACITY];
		int unsigned      entries;
		pct_t             load_pct;
		rsp_t             pending_results [$];
		int unsigned      errors;

		function new();
			for (int i = 0; i < CAPACITY; i++) begin
				slot_key[i] = '0;
				slot_val[i] = '0;
				slot_live[i] = 1'b0;
			end
			entries = 0;
			load_pct = pct_t'(LOAD_LIMIT_RESET);
			errors = 0;
		endfunction

		function void set_load_pct(pct_t p);
			load_pct = p;
		endfunction

		function rsp_t lookup_or_store(req_t w);
			rsp_t        r;
			idx_t        idx;
			bit          hit;
			int unsigned pct;
			int unsigned entry_limit;
			idx = w.key[IDX_W-1:0];
			hit = 1'b0;
			for (int n = 0; n < CAPACITY && !hit; n++) begin
				if (!slot_live[idx] || slot_key[idx] == w.key)
					hit = 1'b1;
				else
					idx = idx + 1'b1;
			end
			if (w.op == OP_GET) begin
				if (hit && slot_live[idx]) begin
					r.status = ST_FOUND;
					r.read_value = slot_val[idx];
				end else begin
					r.status = ST_MISSING;
					r.read_value = '0;
				end
				return r;
			end
			r.read_value = w.data_value;
			r.status = ST_FULL;
			if (!hit)
				return r;
			if (!slot_live[idx]) begin
				pct = (load_pct > PCT_MAX) ? PCT_MAX : load_pct;
				entry_limit = (CAPACITY * pct) / PCT_SCALE;
				if (entries + 1 > entry_limit)
					return r;
				entries++;
			end
			slot_key[idx] = w.key;
			if (w.value_is_empty) begin
				slot_val[idx] = '0;
				slot_live[idx] = 1'b0;
			end else begin
				slot_val[idx] = w.data_value;
				slot_live[idx] = 1'b1;
			end
			r.status = ST_STORED;
			return r;
		endfunction

		function void note_word(req_t w);
			pending_results.push_back(lookup_or_store(w));
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: status %0d read_value %h",
					got.status, got.read_value);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.read_value !== want.read_value) begin
				$error("read_value: expected %h, actual %h", want.read_value, got.read_value);
				errors++;
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  done;
	rsp_t  rsp;
	logic  cfg_valid;
	logic  cfg_ready;
	pct_t  cfg_data;

	hash_map_scoreboard map_sb = new();
	logic [KEY_W-1:0] used_keys [$];

	linear_probe_hash_map uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			map_sb.check_result(rsp);
	end

	function automatic req_t make_word(op_t o, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
			logic nil);
		req_t w;
		w.op = o;
		w.key = k;
		w.data_value = v;
		w.value_is_empty = nil;
		return w;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key(int unsigned fresh_pct);
		logic [KEY_W-1:0] k;
		int unsigned      r;
		r = $urandom_range(0, 99);
		if (r >= fresh_pct && used_keys.size() > 0)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		k = {$urandom, $urandom};
		// clustered home slots either side of the wrap point
		if (r % 3 != 0)
			k[IDX_W-1:0] = idx_t'($urandom_range(0, 47) + 248);
		return k;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic issue(input req_t w, input int unsigned gap);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		map_sb.note_word(w);
		used_keys.push_back(w.key);
		if (used_keys.size() > 128)
			void'(used_keys.pop_front());
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (map_sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_load_pct(input pct_t p);
		drain();
		repeat (2) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= p;
		do @(posedge clk); while (!cfg_ready);
		map_sb.set_load_pct(p);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		pct_t        phase_pct [8];
		int unsigned phase_items [8];
		int unsigned phase_fresh [8];
		op_t         o;
		logic        nil;
		int unsigned gap;

		phase_pct = '{pct_t'(10), pct_t'(45), pct_t'(1), pct_t'(70), pct_t'(99), pct_t'(0),
			pct_t'(127), pct_t'(90)};
		phase_items = '{80, 90, 40, 100, 200, 50, 100, 90};
		phase_fresh = '{60, 60, 40, 70, 80, 40, 50, 40};

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty map, then a cluster on home slot 0 and one wrapping from slot 255
		issue(make_word(OP_GET, 64'h0, 64'h0, 1'b0), 1);
		issue(make_word(OP_SET, 64'h0, '1, 1'b0), 0);
		issue(make_word(OP_GET, 64'h0, 64'h0, 1'b0), 0);
		issue(make_word(OP_SET, 64'h100, 64'h0, 1'b0), 0);
		issue(make_word(OP_SET, '1, 64'h5555_5555_5555_5555, 1'b0), 2);
		issue(make_word(OP_SET, 64'h1ff, 64'ha5a5_a5a5_a5a5_a5a5, 1'b0), 0);
		issue(make_word(OP_GET, 64'h1ff, 64'h0, 1'b0), 0);
		// nil on a live slot empties it, later probes stop there
		issue(make_word(OP_SET, 64'h100, '1, 1'b1), 1);
		issue(make_word(OP_GET, 64'h100, 64'h0, 1'b0), 0);
		issue(make_word(OP_GET, 64'h1ff, 64'h0, 1'b0), 0);
		// nil on an empty slot takes an entry but leaves the slot empty
		issue(make_word(OP_SET, 64'h2ff, 64'h1234, 1'b1), 0);
		issue(make_word(OP_SET, 64'h1ff, 64'h123, 1'b0), 3);
		issue(make_word(OP_GET, 64'h1ff, 64'h0, 1'b0), 0);
		issue(make_word(OP_GET, '1, '1, 1'b1), 0);

		// zero limit refuses new keys, updates still go through
		write_load_pct(pct_t'(0));
		issue(make_word(OP_SET, 64'h77, 64'hdead_beef_0000_0001, 1'b0), 0);
		issue(make_word(OP_SET, 64'h0, 64'h0, 1'b0), 0);
		issue(make_word(OP_GET, 64'h0, 64'h0, 1'b0), 0);
		issue(make_word(OP_SET, 64'h0, 64'h9, 1'b1), 0);

		write_load_pct(pct_t'(1));
		issue(make_word(OP_SET, 64'h42, 64'h8000_0000_0000_0000, 1'b0), 0);
		issue(make_word(OP_SET, 64'h42, 64'h1, 1'b1), 1);

		// above the maximum clamps to 99 percent
		write_load_pct(pct_t'(127));
		issue(make_word(OP_SET, 64'h42, 64'h0123_4567_89ab_cdef, 1'b0), 0);
		issue(make_word(OP_GET, 64'h42, 64'h0, 1'b0), 0);

		for (int ph = 0; ph < 8; ph++) begin
			write_load_pct(phase_pct[ph]);
			for (int i = 0; i < phase_items[ph]; i++) begin
				o = ($urandom_range(0, 99) < 55) ? OP_SET : OP_GET;
				nil = (o == OP_SET) ? ($urandom_range(0, 9) == 0) : 1'($urandom_range(0, 1));
				gap = (i % 64 < 16) ? 0 : pick_gap();
				if ($urandom_range(0, 59) == 0)
					drain();
				issue(make_word(o, pick_key(phase_fresh[ph]), pick_value(), nil), gap);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (map_sb.pending_results.size() != 0) begin
			$error("%0d results never arrived", map_sb.pending_results.size());
			map_sb.errors++;
		end
		if (map_sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
